// ----- rtl/hsi_pkg.sv -----
// ----------------------------------------------------------------------------
// hsi_pkg: shared types and codes for the hash set block
// Key and status types, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package hsi_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 3;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [STATUS_W-1:0]     status_type;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // status codes
   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_DUPLICATE = 3'd1;
   localparam status_type ST_PRESENT   = 3'd2;
   localparam status_type ST_ABSENT    = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

   // main sequencer
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_SCAN,
      S_DRAIN,
      S_RESP
   } hsi_state_type;

   // bucket index unit
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MULQ,
      BK_MULR,
      BK_FOLD,
      BK_ADJ
   } bkt_state_type;

endpackage

// ----- rtl/hsi_bucket.sv -----
// ----------------------------------------------------------------------------
// hsi_bucket: bucket index unit
// Non-negative key mod BUCKETS through one shared 32x32 multiplier:
// reciprocal estimate, back-multiply, one fold, then the sign-offset fix.
// ----------------------------------------------------------------------------
module hsi_bucket #(
   parameter int BUCKETS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  hsi_pkg::key_type           key,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] bucket
);
   import hsi_pkg::*;

   localparam int BW = $clog2(BUCKETS);
   // key is offset by 2^31 to make it unsigned; this folds the offset back
   localparam logic [63:0] RECIP_W   = (64'd1 << 32) / BUCKETS;
   localparam logic [63:0] OFFSET_W  = (64'd1 << 31) % BUCKETS;
   localparam logic [63:0] ADDBACK_W = 64'(BUCKETS) - OFFSET_W;

   bkt_state_type state_ff, state_in;

   logic [31:0]   u_ff, u_in;
   logic [63:0]   prod_ff, prod_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic          done_ff, done_in;

   logic [31:0]   mul_a;
   logic [31:0]   mul_b;
   logic [63:0]   mul_p;
   logic [31:0]   fold_diff;
   logic [BW:0]   wrap_sum;

   // the one shared multiplier
   assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
   assign fold_diff = u_ff - prod_ff[31:0];
   assign wrap_sum  = {1'b0, rem_ff} + (BW+1)'(ADDBACK_W);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) state_in = BK_MULQ;
         end
         BK_MULQ: state_in = BK_MULR;
         BK_MULR: state_in = BK_FOLD;
         BK_FOLD: state_in = BK_ADJ;
         BK_ADJ:  state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      u_in      = u_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      bucket_in = bucket_ff;
      done_in   = 1'b0;
      mul_a     = prod_ff[63:32];
      mul_b     = 32'(BUCKETS);
      case (state_ff)
         BK_IDLE: begin
            if (start) u_in = {~key[31], key[30:0]};
         end
         BK_MULQ: begin
            // quotient estimate, low by at most one
            mul_a   = u_ff;
            mul_b   = RECIP_W[31:0];
            prod_in = mul_p;
         end
         BK_MULR: begin
            mul_a   = prod_ff[63:32];
            mul_b   = 32'(BUCKETS);
            prod_in = mul_p;
         end
         BK_FOLD: begin
            if (fold_diff >= 32'(BUCKETS)) begin
               rem_in = BW'(fold_diff - 32'(BUCKETS));
            end else begin
               rem_in = BW'(fold_diff);
            end
         end
         BK_ADJ: begin
            if (rem_ff >= BW'(OFFSET_W)) begin
               bucket_in = rem_ff - BW'(OFFSET_W);
            end else begin
               bucket_in = BW'(wrap_sum);
            end
            done_in = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff      <= u_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      bucket_ff <= bucket_in;
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

// ----- rtl/hash_set_insert_lookup.sv -----
// ----------------------------------------------------------------------------
// hash_set_insert_lookup: hash set of signed 32-bit keys
// Insert or look up a key in a bucket of WAYS ways, bucket = key mod BUCKETS.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload          direction
//   req       req_valid/req_ready    req_operation    in
//                                    req_key
//   rsp       rsp_valid/rsp_ready    rsp_status       out
//
// Sequence: after acceptance a request runs through the bucket unit (two
// passes through its multiplier), streams the bucket's keys out of the key
// memory one per cycle, drains the compare, answers and goes back to idle
// before the next acceptance.
// Reset: a clearing pass zeroes all BUCKETS valid-bit rows;
// no request is taken until it ends.
// Stalls: the result waits in an output register; the next request is
// taken meanwhile and only its answer cycle waits for rsp_ready.
//
module hash_set_insert_lookup #(
   parameter int BUCKETS = 1024,
   parameter int WAYS    = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  hsi_pkg::key_type       req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hsi_pkg::status_type    rsp_status
);
   import hsi_pkg::*;

   localparam int BW    = $clog2(BUCKETS);
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int DEPTH = BUCKETS * WAYS;
   localparam int IW    = $clog2(DEPTH);

   hsi_state_type state_ff, state_in;

   logic          op_ff, op_in;
   key_type       key_ff, key_in;
   logic [WW-1:0] way_ff, way_in;          // read issue pointer
   logic [WW-1:0] cmp_way_ff, cmp_way_in;  // way of the data in key_q_ff
   logic          cmp_vld_ff, cmp_vld_in;
   logic          found_ff, found_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;

   // key store: one key per way; valid store: one row of WAYS bits per bucket
   key_type       key_mem [DEPTH];
   logic [WAYS-1:0] row_mem [BUCKETS];
   key_type       key_q_ff;
   logic [WAYS-1:0] row_q_ff;

   logic          bkt_start;
   logic          bkt_done;
   logic [BW-1:0] bkt_bucket;

   logic [IW-1:0] base_idx;
   logic [IW-1:0] rd_idx;
   logic [IW-1:0] wr_idx;
   logic          row_we;
   logic [BW-1:0] row_addr;
   logic [WAYS-1:0] row_wdata;
   logic [WAYS-1:0] free_mask;
   logic          key_we;
   logic [WW-1:0] free_way;
   logic          have_free;
   logic          hit;
   logic          load_rsp;

   hsi_bucket #(
      .BUCKETS (BUCKETS)
   ) u_bucket (
      .clock  (clock),
      .reset  (reset),
      .start  (bkt_start),
      .key    (req_key),
      .done   (bkt_done),
      .bucket (bkt_bucket)
   );

   // bucket stays put from done until the unit finishes the next request
   assign base_idx  = IW'(bkt_bucket) * IW'(WAYS);
   assign rd_idx    = base_idx + IW'(way_ff);
   assign wr_idx    = base_idx + IW'(free_way);
   assign free_mask = WAYS'(1) << free_way;

   // lowest free way of the bucket row
   always_comb begin
      have_free = 1'b0;
      free_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!row_q_ff[w]) begin
            have_free = 1'b1;
            free_way  = WW'(w);
         end
      end
   end

   // shared compare: one way per cycle, in the cycle after its read
   assign hit = cmp_vld_ff && row_q_ff[cmp_way_ff] && (key_q_ff == key_ff);

   assign load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == BW'(BUCKETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_HASH;
         end
         S_HASH: begin
            if (bkt_done) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (way_ff == WW'(WAYS - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_RESP;
         S_RESP: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready     = 1'b0;
      bkt_start     = 1'b0;
      op_in         = op_ff;
      key_in        = key_ff;
      way_in        = way_ff;
      cmp_way_in    = way_ff;
      cmp_vld_in    = 1'b0;
      found_in      = found_ff | hit;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      row_we        = 1'b0;
      row_addr      = bkt_bucket;
      row_wdata     = row_q_ff | free_mask;
      key_we        = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            row_we    = 1'b1;
            row_addr  = clr_ff;
            row_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bkt_start = 1'b1;
               op_in     = req_operation;
               key_in    = req_key;
               way_in    = '0;
               found_in  = 1'b0;
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (way_ff != WW'(WAYS - 1)) way_in = way_ff + 1'b1;
         end
         S_RESP: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_LOOKUP) begin
                  rsp_status_in = found_ff ? ST_PRESENT : ST_ABSENT;
               end else if (found_ff) begin
                  rsp_status_in = ST_DUPLICATE;
               end else if (have_free) begin
                  rsp_status_in = ST_INSERTED;
                  row_we        = 1'b1;
                  key_we        = 1'b1;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      way_ff        <= way_in;
      cmp_way_ff    <= cmp_way_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_idx] <= key_ff;
      key_q_ff <= key_mem[rd_idx];
   end

   // valid-bit rows: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_addr] <= row_wdata;
      row_q_ff <= row_mem[bkt_bucket];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_HASH))
      else $error("accepted request did not start the bucket unit");

   a_done_only_in_hash: assert property (@(posedge clock) disable iff (reset)
      bkt_done |-> (state_ff == S_HASH))
      else $error("bucket unit finished outside the hash wait");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      bkt_done |-> (bkt_bucket <= BW'(BUCKETS - 1)))
      else $error("bucket index out of range");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && found_ff) |->
         (rsp_status_in == ST_DUPLICATE || rsp_status_in == ST_PRESENT))
      else $error("matched key answered with a miss status");

   a_store_free_way: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (op_ff == OP_INSERT && !found_ff && !row_q_ff[free_way]))
      else $error("key written over a valid way or on a non-insert");

endmodule

// ----- tb/hash_set_insert_lookup_checker.sv -----
// ----------------------------------------------------------------------------
// hash_set_insert_lookup_checker: status predictor and scoreboard
// Mirrors the bucket ways, predicts the status of every accepted request and
// compares each returned status with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hash_set_insert_lookup_checker #(
   parameter int BUCKETS = 1024,
   parameter int WAYS    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_operation,
   input  hsi_pkg::key_type    req_key,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  hsi_pkg::status_type rsp_status,
   output int unsigned         fault_count = 0,
   output int unsigned         outstanding = 0
);
   import hsi_pkg::*;

   localparam int REPORT_MAX = 10;

   typedef struct {
      logic       op;
      key_type    key;
      status_type status;
   } answer_type;

   logic       occupied   [BUCKETS*WAYS];
   key_type    stored_key [BUCKETS*WAYS];
   answer_type answers_due[$];
   int unsigned errors = 0;

   // non-negative remainder, so negative keys map into 0..BUCKETS-1
   function automatic int bucket_of(input key_type k);
      longint signed wide;
      wide = k;
      wide = wide % BUCKETS;
      if (wide < 0) begin
         wide += BUCKETS;
      end
      return int'(wide);
   endfunction

   // predicts the answer and updates the mirrored ways
   function automatic status_type predict_status(input logic op, input key_type k);
      int base;
      int free_slot;
      bit hit;
      base      = bucket_of(k) * WAYS;
      free_slot = -1;
      hit       = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (occupied[base + w]) begin
            if (stored_key[base + w] == k) begin
               hit = 1'b1;
            end
         end else if (free_slot < 0) begin
            free_slot = base + w;
         end
      end
      if (op == OP_LOOKUP) begin
         return hit ? ST_PRESENT : ST_ABSENT;
      end
      if (hit) begin
         return ST_DUPLICATE;
      end
      if (free_slot < 0) begin
         return ST_FULL;
      end
      occupied[free_slot]   = 1'b1;
      stored_key[free_slot] = k;
      return ST_INSERTED;
   endfunction

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         answers_due.delete();
         for (int i = 0; i < BUCKETS*WAYS; i++) begin
            occupied[i] = 1'b0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX) begin
                  $display("%0t: status %0d returned with no request pending",
                           $realtime, rsp_status);
               end
            end else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("%0t: op %0d key %0d: status expected %0d, got %0d",
                              $realtime, due.op, due.key, due.status, rsp_status);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            due.op     = req_operation;
            due.key    = req_key;
            due.status = predict_status(req_operation, req_key);
            answers_due.push_back(due);
         end
      end
      fault_count <= errors;
      outstanding <= answers_due.size();
   end

endmodule

// ----- tb/hash_set_insert_lookup_tb.sv -----
// ----------------------------------------------------------------------------
// hash_set_insert_lookup_tb: testbench top for the hash set block
// Drives insert and lookup requests with random idling on both channels;
// the checker beside the block predicts and compares every status.
// ----------------------------------------------------------------------------
module hash_set_insert_lookup_tb;
   import hsi_pkg::*;

   localparam int BUCKETS = 1024;
   localparam int WAYS    = 4;

   // random part: most keys crowd a few hot buckets so that ways fill up
   // and duplicates and full answers are common
   localparam int RANDOM_ITEMS = 1380;
   localparam int CALM_ITEMS   = 150;    // tail with no idling on either side
   localparam int HOT_BUCKETS  = 32;
   localparam int HISTORY_MAX  = 512;

   // longest legal quiet stretch is the clearing pass after reset; other
   // stalls (sender gap, receiver stall, block cycles) are far shorter
   localparam int WATCHDOG_LIMIT = 4 * (BUCKETS + 2*16 + WAYS + 8);

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = OP_INSERT;
   key_type    req_key = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   status_type rsp_status;

   int unsigned fault_count;
   int unsigned outstanding;
   int unsigned stall_cycles = 0;
   bit          calm = 1'b0;      // set for the last stretch: no idling
   key_type     known_keys[$];    // keys sent for insert, reused for hits

   hash_set_insert_lookup #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status)
   );

   hash_set_insert_lookup_checker #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .fault_count   (fault_count),
      .outstanding   (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random bursts of ready and stall, always ready once calm;
   // a burst in progress is cut short when the calm stretch begins
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         repeat ($urandom_range(1, 16)) begin
            @(posedge clock);
            if (calm) break;
         end
      end
   end

   // watchdog: cycles with no request and no status accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[hash_set_insert_lookup] ERROR");
      $finish;
   end

   // one request; optional idle burst first, then hold until accepted.
   // Valid stays high into the next request unless a gap follows.
   task automatic send_request(input logic op, input key_type k);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_INSERT && known_keys.size() < HISTORY_MAX) begin
         known_keys.push_back(k);
      end
   endtask

   // sender holds off until every status owed has come back
   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);   // let the count take in the last acceptance
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic key_type pick_key();
      int      sel;
      key_type k;
      sel = $urandom_range(0, 9);
      if (sel < 4 && known_keys.size() > 0) begin
         k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (sel < 8) begin
         // hot bucket plus a small multiple of the bucket count, either sign
         k = $urandom_range(0, 9) * BUCKETS + $urandom_range(0, HOT_BUCKETS - 1);
         if ($urandom_range(0, 1)) begin
            k = -k;
         end
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   initial begin
      logic op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty bucket, duplicate, extremes of the key
      send_request(OP_LOOKUP, 32'sd0);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_LOOKUP, 32'sd0);
      send_request(OP_INSERT, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000);   // most negative key, bucket 0
      send_request(OP_INSERT, -32'sd1);         // shares the top bucket
      send_request(OP_LOOKUP, 32'h7FFF_FFFF);
      send_request(OP_LOOKUP, 32'h8000_0000);
      send_request(OP_INSERT, -32'sd1);
      // fill bucket 0 with positive and negative keys, then overflow it
      send_request(OP_INSERT, BUCKETS);
      send_request(OP_INSERT, -BUCKETS);
      send_request(OP_INSERT, 2 * BUCKETS);     // bucket full
      send_request(OP_INSERT, -2 * BUCKETS);    // bucket full
      send_request(OP_LOOKUP, 2 * BUCKETS);     // full bucket, key missing
      send_request(OP_LOOKUP, -BUCKETS);        // full bucket, key there
      send_request(OP_INSERT, 32'sd0);          // full bucket, duplicate wins
      send_request(OP_INSERT, 32'h5555_5555);
      send_request(OP_INSERT, 32'hAAAA_AAAA);
      send_request(OP_LOOKUP, 32'hAAAA_AAAA);
      send_request(OP_LOOKUP, 32'h5555_1555);   // same bucket, different key
      drain_answers();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            drain_answers();
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
         end
         op = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
         send_request(op, pick_key());
      end

      drain_answers();
      repeat (2 * (WAYS + 8)) @(posedge clock);
      if (fault_count == 0 && outstanding == 0) begin
         $display("[hash_set_insert_lookup] OK");
      end else begin
         $display("[hash_set_insert_lookup] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/hsi_pkg.sv
rtl/hsi_bucket.sv
rtl/hash_set_insert_lookup.sv
tb/hash_set_insert_lookup_checker.sv
tb/hash_set_insert_lookup_tb.sv
